### rtl/sha_pkg.sv
// sha_pkg: constants, types and round functions for the sha-256 stream hasher
// used by sha_block_buf, sha_core and sha256_stream_hasher
package sha_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_WAIT,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_LOAD,
		CS_ROUND,
		CS_FOLD
	} core_state_t;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	typedef struct packed {
		logic  start;
		logic  bank;
	} blk_req_t;

endpackage

### rtl/sha_block_buf.sv
// sha_block_buf: two-bank block memory, bytes in, 32-bit words out
// depends on sha_pkg
module sha_block_buf (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic                 wr_bank,
	input  logic [5:0]           wr_addr,
	input  logic [7:0]           wr_byte,
	input  logic                 rd_bank,
	input  logic [3:0]           rd_addr,
	output sha_pkg::word_t       rd_word
);
	import sha_pkg::*;

	logic [7:0] mem0 [32];
	logic [7:0] mem1 [32];
	logic [7:0] mem2 [32];
	logic [7:0] mem3 [32];
	logic [4:0] wa;
	logic [4:0] ra;

	assign wa = {wr_bank, wr_addr[5:2]};
	assign ra = {rd_bank, rd_addr};

	always_ff @(posedge clk) begin
		if (wr_en && wr_addr[1:0] == 2'd0) mem0[wa] <= wr_byte;
		if (wr_en && wr_addr[1:0] == 2'd1) mem1[wa] <= wr_byte;
		if (wr_en && wr_addr[1:0] == 2'd2) mem2[wa] <= wr_byte;
		if (wr_en && wr_addr[1:0] == 2'd3) mem3[wa] <= wr_byte;
		rd_word <= {mem0[ra], mem1[ra], mem2[ra], mem3[ra]};
	end

endmodule

### rtl/sha_core.sv
// sha_core: 64-round compression with hash state and schedule in memories
// depends on sha_pkg; reads words from sha_block_buf
module sha_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha_pkg::blk_req_t    req,
	input  logic                 reinit,
	output logic                 busy,
	output logic                 rd_bank,
	output logic [3:0]           rd_addr,
	input  sha_pkg::word_t       rd_word,
	input  logic [2:0]           h_idx,
	output sha_pkg::word_t       h_word
);
	import sha_pkg::*;

	core_state_t state_q, state_d;
	logic [6:0]  cnt_q;
	logic        bank_q;
	logic        init_q;
	word_t       a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	word_t       hmem [8];
	word_t       wmem [16];
	word_t       w2_q, w7_q, w15_q, w16_q;
	word_t       hrd_s1;
	logic [5:0]  t;
	word_t       w_cur, t1, t2;
	logic [3:0]  ti;
	logic [2:0]  fi;

	// schedule held in four 16-entry copies, one per tap
	word_t wm2 [16];
	word_t wm7 [16];
	word_t wm15 [16];

	assign t = cnt_q[5:0];
	assign ti = t[3:0];
	assign w_cur = (t < 6'd16) ? rd_word : ssig1(w2_q) + w7_q + ssig0(w15_q) + w16_q;
	assign t1 = h_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[t] + w_cur;
	assign t2 = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	assign busy = (state_q != CS_IDLE) || init_q;
	assign rd_bank = bank_q;
	assign fi = cnt_q[2:0];

	always_comb begin
		rd_addr = (state_q == CS_IDLE) ? 4'd0 : ti + 4'd1;
		if (state_q == CS_LOAD) rd_addr = 4'd0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:  if (req.start) state_d = CS_LOAD;
			CS_LOAD:  if (cnt_q[3:0] == 4'd8) state_d = CS_ROUND;
			CS_ROUND: if (t == 6'd63) state_d = CS_FOLD;
			CS_FOLD:  if (cnt_q[3:0] == 4'd8) state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			cnt_q   <= '0;
			bank_q  <= 1'b0;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q != state_d || reinit) cnt_q <= '0;
			else cnt_q <= cnt_q + 7'd1;
			if (state_q == CS_IDLE && req.start) bank_q <= req.bank;
			if (init_q) begin
				if (cnt_q[2:0] == 3'd7) init_q <= 1'b0;
			end
			if (reinit) init_q <= 1'b1;
		end
	end

	// hash memory: one read port registered, one write port
	always_ff @(posedge clk) begin
		if (init_q && state_q == CS_IDLE) hmem[cnt_q[2:0]] <= INIT_H[cnt_q[2:0]];
		else if (state_q == CS_FOLD && cnt_q[3:0] != 4'd0)
			hmem[cnt_q[2:0] - 3'd1] <= hrd_s1 + a_q;
		hrd_s1 <= hmem[state_q == CS_IDLE ? h_idx : fi];
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_LOAD && cnt_q[3:0] != 4'd0) begin
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q} <= {b_q, c_q, d_q, e_q, f_q, g_q, h_q};
			h_q <= hrd_s1;
		end else if (state_q == CS_ROUND) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
			wmem[ti] <= w_cur;
			wm2[ti] <= w_cur;
			wm7[ti] <= w_cur;
			wm15[ti] <= w_cur;
		end else if (state_q == CS_FOLD && cnt_q[3:0] != 4'd0) begin
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q} <= {b_q, c_q, d_q, e_q, f_q, g_q, h_q};
		end
		// taps for round t+1
		w16_q <= wmem[ti + 4'd1];
		w15_q <= wm15[ti + 4'd2];
		w7_q  <= wm7[ti + 4'd10];
		w2_q  <= wm2[ti + 4'd15];
	end

	assign h_word = hrd_s1;

endmodule

### rtl/sha256_stream_hasher.sv
// sha256_stream_hasher: streaming sha-256 engine, top level
// depends on sha_pkg, sha_block_buf, sha_core
//
// input channel s_axis: cmd in tuser, data_byte in tdata; absorb transfers
// carry one message byte, a finish transfer pads the message and emits the
// digest. output channel m_axis: eight transfers, word 0 first, tlast on 7.
// bytes are written into a two-bank block memory, one per cycle; a full
// block hands its bank to the compression core and filling goes on in the
// other bank. the core loads the state, runs 64 rounds and then folds the
// result into the hash memory, so absorb runs at one byte per cycle except
// for a stall while a full block waits for the core to take it.
// a finish writes padding and length at one byte per cycle, stalling while
// a full block waits, waits for the last blocks, then reads the hash memory
// one word per cycle into the output register while the receiver is ready.
// reset clears control state; the core then loads the initial hash value,
// absorb transfers are taken meanwhile and compression waits.
// when the receiver stalls, the output word holds and no new input is taken
// until all eight words are delivered.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zeros
	output logic        m_axis_tlast    // last
);
	import sha_pkg::*;

	ctl_state_t  state_q, state_d;
	logic [5:0]  fill_q;
	logic        bank_q;
	logic [60:0] bytes_q;
	logic [63:0] len_q;
	logic [2:0]  lcnt_q;
	logic        pend_q;
	logic        pbank_q;
	logic [3:0]  ocnt_q;
	logic        ovalid_q;
	logic [31:0] oword_q;
	logic [2:0]  oidx_q;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic        busy;
	logic        rd_bank;
	logic [3:0]  rd_addr;
	word_t       rd_word;
	word_t       h_word;
	blk_req_t    req;
	logic        reinit;
	logic        acc;
	logic        full;
	logic        can_wr;
	logic        adv;
	logic [2:0]  hidx;

	// a write may go on unless a full block is still waiting for the core
	assign can_wr = !pend_q;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && can_wr;

	// hash read address: next word when advancing, else hold the waiting word
	assign adv = (state_q == ST_EMIT) && (!ovalid_q || m_axis_tready) && ocnt_q < 4'd8;
	assign hidx = adv ? ocnt_q[2:0] : ocnt_q[2:0] - 3'd1;

	always_comb begin
		wr_en = 1'b0;
		wr_byte = s_axis_tdata;
		unique case (state_q)
			ST_IDLE: if (acc) begin
				wr_en = 1'b1;
				wr_byte = (s_axis_tuser == CMD_FINISH) ? PAD_BYTE : s_axis_tdata;
			end
			ST_PAD: if (can_wr) begin
				wr_en = 1'b1;
				wr_byte = 8'h00;
			end
			ST_LEN: if (can_wr) begin
				wr_en = 1'b1;
				wr_byte = len_q[63:56];
			end
			default: ;
		endcase
	end

	assign full = wr_en && fill_q == 6'd63;
	assign req.start = pend_q && !busy;
	assign req.bank = pbank_q;
	assign reinit = (state_q == ST_EMIT) && m_axis_tready && ovalid_q && oidx_q == 3'd7;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc && s_axis_tuser == CMD_FINISH)
				state_d = (fill_q == 6'd55) ? ST_LEN : ST_PAD;
			ST_PAD:  if (can_wr && fill_q == 6'd55) state_d = ST_LEN;
			ST_LEN:  if (can_wr && lcnt_q == 3'd7) state_d = ST_WAIT;
			ST_WAIT: if (!pend_q && !busy && !req.start) state_d = ST_EMIT;
			ST_EMIT: if (reinit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bank_q  <= 1'b0;
			bytes_q <= '0;
			lcnt_q  <= '0;
			pend_q  <= 1'b0;
			pbank_q <= 1'b0;
			ocnt_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) fill_q <= fill_q + 6'd1;
			if (full) begin
				bank_q <= !bank_q;
				pbank_q <= bank_q;
			end
			if (full) pend_q <= 1'b1;
			else if (req.start) pend_q <= 1'b0;
			if (acc && s_axis_tuser == CMD_ABSORB) bytes_q <= bytes_q + 61'd1;
			if (state_q == ST_LEN && can_wr) lcnt_q <= lcnt_q + 3'd1;
			if (state_q == ST_EMIT) begin
				if (ocnt_q < 4'd8 && (!ovalid_q || m_axis_tready)) ocnt_q <= ocnt_q + 4'd1;
				if (ocnt_q != 4'd0 && ocnt_q <= 4'd8 && (!ovalid_q || m_axis_tready))
					ovalid_q <= 1'b1;
				else if (m_axis_tready) ovalid_q <= 1'b0;
			end
			if (reinit) begin
				bytes_q <= '0;
				ocnt_q  <= '0;
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && s_axis_tuser == CMD_FINISH) len_q <= {bytes_q, 3'b000};
		else if (state_q == ST_LEN && can_wr) len_q <= {len_q[55:0], 8'h00};
		if (state_q == ST_EMIT && ocnt_q != 4'd0 && (!ovalid_q || m_axis_tready)) begin
			oword_q <= h_word;
			oidx_q  <= ocnt_q[2:0] - 3'd1;
		end
	end

	sha_block_buf u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_bank (bank_q),
		.wr_addr (fill_q),
		.wr_byte (wr_byte),
		.rd_bank (rd_bank),
		.rd_addr (rd_addr),
		.rd_word (rd_word)
	);

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.reinit  (reinit),
		.busy    (busy),
		.rd_bank (rd_bank),
		.rd_addr (rd_addr),
		.rd_word (rd_word),
		.h_idx   (hidx),
		.h_word  (h_word)
	);

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, oidx_q, oword_q};
	assign m_axis_tlast  = (oidx_q == 3'd7);

endmodule

### tb/sha256_stream_hasher_test.sv
// testbench for sha256_stream_hasher: byte stream in, eight digest words out
// a sha-256 predictor in a scoreboard class checks every output transfer
// depends on sha_pkg for command codes, padding and round constants and the initial hash value
module sha256_stream_hasher_test;
	import sha_pkg::*;

	class digest_board;
		logic [31:0] hash_state [8];
		logic [7:0] blk [64];
		logic [31:0] sched [16];
		int fill;
		logic [63:0] msg_bits;
		logic [39:0] pending [$];
		int errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
			fill = 0;
			msg_bits = 0;
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] v [8];
			logic [31:0] w, t1, t2, a2, a15;
			for (int i = 0; i < 8; i++) v[i] = hash_state[i];
			for (int t = 0; t < 64; t++) begin
				if (t < 16) begin
					w = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
				end else begin
					a2 = sched[(t - 2) & 15];
					a15 = sched[(t - 15) & 15];
					w = (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10)) + sched[(t - 7) & 15]
						+ (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3)) + sched[t & 15];
				end
				sched[t & 15] = w;
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) hash_state[i] += v[i];
		endfunction

		function void push(logic [7:0] b);
			blk[fill] = b;
			fill = (fill + 1) & 63;
			if (fill == 0) compress();
		endfunction

		function void note_input(logic cmd, logic [7:0] b);
			logic [63:0] len;
			if (cmd == CMD_ABSORB) begin
				msg_bits += 64'd8;
				push(b);
				return;
			end
			len = msg_bits;
			push(PAD_BYTE);
			while (fill != LEN_POS) push(8'h00);
			for (int i = 0; i < 8; i++) push(len[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++)
				pending.push_back({(i == 7), 3'(i), hash_state[i]});
			restart();
		endfunction

		function void check_output(logic [39:0] data, logic lst);
			logic [39:0] exp_w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected output transfer %h last %b", $time, data, lst);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (data[31:0] !== exp_w[31:0] || data[34:32] !== exp_w[34:32]
					|| data[39:35] !== 5'd0 || lst !== exp_w[35]) begin
				$display("%0t: mismatch expected word %h index %0d last %b, got %h index %0d last %b",
					$time, exp_w[31:0], exp_w[34:32], exp_w[35], data[31:0], data[34:32], lst);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [39:0] m_axis_tdata;
	logic m_axis_tlast;

	digest_board board = new();
	int burst_left = 0;
	bit long_hold = 0;

	sha256_stream_hasher uut (.*);

	always #5 clk = ~clk;

	task automatic send_item(logic cmd, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(cmd, b);
	endtask

	task automatic send_message(int len, int mode);
		for (int i = 0; i < len; i++)
			send_item(CMD_ABSORB, mode == 1 ? 8'hff : mode == 2 ? 8'h00 : 8'($urandom));
		send_item(CMD_FINISH, 8'($urandom));
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_output(m_axis_tdata, m_axis_tlast);
	end

	// receiver: random stall pattern, with one long hold-off counted here
	initial begin
		int phase;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (600) @(posedge clk);
				long_hold = 0;
			end
			else if ((phase / 64) % 3 == 0) m_axis_tready <= 1;
			else m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty message, extreme bytes, padding boundaries
		send_message(0, 0);
		drain();
		send_message(1, 1);
		send_message(1, 2);
		send_message(3, 0);
		drain();
		send_message(55, 0);
		send_message(56, 0);
		drain();
		// long hold-off while the sender keeps going
		long_hold = 1;
		send_message(40, 0);
		send_message(5, 0);
		drain();
		send_message(63, 1);
		send_message(64, 0);
		// random part, mostly short messages
		repeat (8) begin
			send_message($urandom_range(0, 3) == 0 ? $urandom_range(0, 20)
				: $urandom_range(0, 4), $urandom_range(0, 5) == 0 ? 1 : 0);
			if ($urandom_range(0, 4) == 0) drain();
		end
		drain();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
